// File: sv/spim_pkg.sv
// Package: beat types, register indexes and bit helpers for the SPI master shift engine.
package spim_pkg;

   localparam logic [7:0] LSB_MASK = 8'h01;
   localparam logic [7:0] MSB_MASK = 8'h80;

   typedef enum logic [1:0] {
      CSR_SPI_MODE     = 2'd0,
      CSR_TX_LSB_FIRST = 2'd1,
      CSR_RX_LSB_FIRST = 2'd2,
      CSR_HALF_PERIOD  = 2'd3
   } csr_index_type;

   typedef enum logic {
      REQ_TICK  = 1'b0,
      REQ_START = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] tx_byte;
      logic       tx_enable;
      logic       rx_enable;
      logic       drive_enable;
      logic       miso;
   } req_beat_type;

   typedef struct packed {
      logic       sclk;
      logic       mosi;
      logic       mosi_drive;
      logic       busy_res;
      logic [7:0] rx_byte;
      logic       rx_valid;
   } rsp_beat_type;

   typedef struct packed {
      logic [1:0]  spi_mode;
      logic        tx_lsb_first;
      logic        rx_lsb_first;
      logic [15:0] half_period;
   } cfg_type;

   // Mask for bit position idx in the chosen order.
   function automatic logic [7:0] bit_mask(input logic lsb_first, input logic [2:0] idx);
      logic [7:0] m;
      if (lsb_first) begin
         m = LSB_MASK << idx;
      end else begin
         m = MSB_MASK >> idx;
      end
      return m;
   endfunction

endpackage

// File: sv/spim_csr.sv
// Configuration registers of the SPI master shift engine.
module spim_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  spim_pkg::csr_index_type csr_index,
   input  logic [15:0]           csr_wdata,
   output spim_pkg::cfg_type     cfg
);
   import spim_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SPI_MODE:     cfg_ff.spi_mode     <= csr_wdata[1:0];
            CSR_TX_LSB_FIRST: cfg_ff.tx_lsb_first <= csr_wdata[0];
            CSR_RX_LSB_FIRST: cfg_ff.rx_lsb_first <= csr_wdata[0];
            CSR_HALF_PERIOD:  cfg_ff.half_period  <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

// File: sv/spim_core.sv
// Bit timing state and next-state logic: one tick or start per accepted beat.
module spim_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  spim_pkg::req_beat_type req,
   input  spim_pkg::cfg_type     cfg,
   output spim_pkg::rsp_beat_type rsp
);
   import spim_pkg::*;

   logic        sclk_ff, sclk_in;
   logic        mosi_ff, mosi_in;
   logic        drive_ff, drive_in;
   logic        busy_ff, busy_in;
   logic [7:0]  tx_shift_ff, tx_shift_in;
   logic [7:0]  rx_shift_ff, rx_shift_in;
   logic [2:0]  bit_ff, bit_in;
   logic        second_ff, second_in;
   logic [15:0] tick_ff, tick_in;
   logic        tx_act_ff, tx_act_in;
   logic        rx_act_ff, rx_act_in;
   logic        valid_out;
   logic [7:0]  byte_out;
   logic        cpol, cpha;

   assign cpol = cfg.spi_mode[1];
   assign cpha = cfg.spi_mode[0];

   always_comb begin
      sclk_in     = sclk_ff;
      mosi_in     = mosi_ff;
      drive_in    = drive_ff;
      busy_in     = busy_ff;
      tx_shift_in = tx_shift_ff;
      rx_shift_in = rx_shift_ff;
      bit_in      = bit_ff;
      second_in   = second_ff;
      tick_in     = tick_ff;
      tx_act_in   = tx_act_ff;
      rx_act_in   = rx_act_ff;
      valid_out   = 1'b0;
      byte_out    = '0;
      if (req.req_type == REQ_START) begin
         // drop a start while a byte is in flight
         if (!busy_ff) begin
            tx_shift_in = req.tx_byte;
            tx_act_in   = req.tx_enable;
            rx_act_in   = req.rx_enable;
            drive_in    = req.drive_enable;
            rx_shift_in = '0;
            bit_in      = '0;
            busy_in     = 1'b1;
            sclk_in     = cpha ? ~cpol : cpol;
            if (req.tx_enable) begin
               mosi_in = |(req.tx_byte & bit_mask(cfg.tx_lsb_first, 3'd0));
            end
            second_in = 1'b0;
            tick_in   = '0;
         end
      end else if (!busy_ff) begin
         sclk_in = cpol;
      end else if (tick_ff < cfg.half_period) begin
         tick_in = tick_ff + 16'd1;
      end else if (!second_ff) begin
         // end of first half: sample MISO
         sclk_in = cpha ? cpol : ~cpol;
         if (rx_act_ff && req.miso) begin
            rx_shift_in = rx_shift_ff | bit_mask(cfg.rx_lsb_first, bit_ff);
         end
         second_in = 1'b1;
         tick_in   = '0;
      end else if (bit_ff == 3'd7) begin
         busy_in   = 1'b0;
         sclk_in   = cpol;
         second_in = 1'b0;
         tick_in   = '0;
         bit_in    = '0;
         if (rx_act_ff) begin
            valid_out = 1'b1;
            byte_out  = rx_shift_ff;
         end
      end else begin
         // advance to the next bit
         bit_in  = bit_ff + 3'd1;
         sclk_in = cpha ? ~cpol : cpol;
         if (tx_act_ff) begin
            mosi_in = |(tx_shift_ff & bit_mask(cfg.tx_lsb_first, bit_ff + 3'd1));
         end
         second_in = 1'b0;
         tick_in   = '0;
      end
   end

   always_comb begin
      rsp.sclk       = sclk_in;
      rsp.mosi       = mosi_in;
      rsp.mosi_drive = drive_in;
      rsp.busy_res   = busy_in;
      rsp.rx_byte    = byte_out;
      rsp.rx_valid   = valid_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sclk_ff     <= 1'b0;
         mosi_ff     <= 1'b0;
         drive_ff    <= 1'b1;
         busy_ff     <= 1'b0;
         tx_shift_ff <= '0;
         rx_shift_ff <= '0;
         bit_ff      <= '0;
         second_ff   <= 1'b0;
         tick_ff     <= '0;
         tx_act_ff   <= 1'b0;
         rx_act_ff   <= 1'b0;
      end else if (accept) begin
         sclk_ff     <= sclk_in;
         mosi_ff     <= mosi_in;
         drive_ff    <= drive_in;
         busy_ff     <= busy_in;
         tx_shift_ff <= tx_shift_in;
         rx_shift_ff <= rx_shift_in;
         bit_ff      <= bit_in;
         second_ff   <= second_in;
         tick_ff     <= tick_in;
         tx_act_ff   <= tx_act_in;
         rx_act_ff   <= rx_act_in;
      end
   end

endmodule

// File: sv/spim_rsp_buf.sv
// Output register with skid stage for result beats.
module spim_rsp_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  spim_pkg::rsp_beat_type push_data,
   output logic                   full,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output spim_pkg::rsp_beat_type rsp_data
);
   import spim_pkg::*;

   logic         out_valid_ff;
   logic         skid_valid_ff;
   rsp_beat_type out_ff;
   rsp_beat_type skid_ff;
   logic         out_free;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : push_data;
      end
      if (!out_free && push) begin
         skid_ff <= push_data;
      end
   end

endmodule

// File: sv/spi_master_shift_engine.sv
// Top level of the SPI master shift engine (modes 0 to 3).
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+--------------------------------
//  req     | in  | req_valid / req_stall | req_beat_type: tick or start
//  rsp     | out | rsp_valid / rsp_stall | rsp_beat_type: line levels, rx
//  csr     | in  | csr_valid / csr_ready | csr_index, csr_wdata (16 bits)
//
// Every req beat is one tick of serial time (or a start) and yields one rsp
// beat. A beat is accepted every cycle while req_stall is low; its result
// comes from one pass through the core's next-state logic and is registered.
// Synchronous active-high reset returns all timing state to the mode 0 idle
// levels with MOSI driven low. A stall on rsp is absorbed by a skid stage;
// req_stall rises only when both the output register and skid are full.
module spi_master_shift_engine (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  spim_pkg::req_beat_type  req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output spim_pkg::rsp_beat_type  rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  spim_pkg::csr_index_type csr_index,
   input  logic [15:0]             csr_wdata
);
   import spim_pkg::*;

   cfg_type      cfg;
   rsp_beat_type core_rsp;
   logic         accept;
   logic         buf_full;

   // advance the engine on every accepted beat
   assign req_stall = buf_full;
   assign accept    = req_valid && !req_stall;

   spim_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   spim_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg),
      .rsp    (core_rsp)
   );

   // hold results here while the consumer stalls
   spim_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (core_rsp),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sv/spim_checker.sv
// Port-level checks for the SPI master shift engine, bound to the top level.
module spim_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input spim_pkg::rsp_beat_type rsp_data
);
   import spim_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rx_valid |-> !rsp_data.busy_res)
      else $error("received byte reported while still busy");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.rx_valid |-> rsp_data.rx_byte == 8'd0)
      else $error("rx_byte nonzero without rx_valid");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !req_stall)
      else $error("input still stalled after a result beat drained");

endmodule

bind spi_master_shift_engine spim_checker u_spim_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
